// ----- hdl/sss_pkg.sv -----
// sss_pkg: types, constants and helpers for the sensor sampling sequencer
// used by sss_step and sensor_sampling_sequencer_top; no dependencies
package sss_pkg;

  // counter and period widths
  localparam int COUNT_WIDTH  = 16;
  localparam int PERIOD_WIDTH = 16;
  localparam int CFG_IDX_WIDTH = 2;

  typedef logic [COUNT_WIDTH-1:0]   count_t;
  typedef logic [PERIOD_WIDTH-1:0]  period_t;
  typedef logic [CFG_IDX_WIDTH-1:0] cfg_idx_t;

  // configuration register indexes
  localparam cfg_idx_t CFG_WARMUP  = 2'd0;
  localparam cfg_idx_t CFG_SLEEP   = 2'd1;
  localparam cfg_idx_t CFG_REFRESH = 2'd2;

  // command codes
  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_INIT    = 2'd1,
    CMD_REQUEST = 2'd2,
    CMD_FAULT   = 2'd3
  } command_t;

  // sequencer phases
  typedef enum logic [2:0] {
    PH_WARMUP  = 3'd0,
    PH_READY   = 3'd1,
    PH_BUSY    = 3'd2,
    PH_SLEEP   = 3'd3,
    PH_TIMEOUT = 3'd4,
    PH_ERROR   = 3'd5
  } phase_t;

  // input item
  typedef struct packed {
    command_t command;
    logic     update_done;
    logic     data_ready;
    logic     fault_kind;
  } in_item_t;

  // result item
  typedef struct packed {
    phase_t phase;
    logic   update_pending;
    logic   start_update;
    logic   poll_busy;
  } out_item_t;

  // period registers
  typedef struct packed {
    period_t warmup_period;
    period_t sleep_period;
    period_t refresh_period;
  } cfg_t;

  // sequencer state
  typedef struct packed {
    phase_t phase;
    logic   pending;
    count_t warmup_count;
    count_t sleep_count;
    count_t refresh_count;
  } seq_state_t;

  // period taken modulo 2^COUNT_WIDTH when loaded into a counter
  function automatic count_t load_count(input period_t p);
    logic [PERIOD_WIDTH+COUNT_WIDTH-1:0] wide;
    wide = {{COUNT_WIDTH{1'b0}}, p};
    return wide[COUNT_WIDTH-1:0];
  endfunction

endpackage

// ----- hdl/sss_step.sv -----
// sss_step: next-state and result logic for one command item
// depends on sss_pkg
module sss_step
  import sss_pkg::*;
(
  input  seq_state_t st,
  input  cfg_t       cfg,
  input  in_item_t   item,
  output seq_state_t st_next,
  output out_item_t  res
);

  logic start;
  logic poll;
  logic sleep_en;
  logic refresh_en;
  logic warmup_en;
  seq_state_t fin;

  assign sleep_en   = (cfg.sleep_period != '0);
  assign refresh_en = (cfg.refresh_period != '0);
  assign warmup_en  = (cfg.warmup_period != '0);

  // finish-sample outcome: clear request, then sleep or ready
  always_comb begin
    fin = st;
    fin.pending = 1'b0;
    if (sleep_en) begin
      fin.phase       = PH_SLEEP;
      fin.sleep_count = load_count(cfg.sleep_period);
    end else begin
      fin.phase = PH_READY;
      if (refresh_en) begin
        fin.refresh_count = load_count(cfg.refresh_period);
      end
    end
  end

  // command decode and phase stepping
  always_comb begin
    st_next = st;
    start   = 1'b0;
    poll    = 1'b0;
    case (item.command)
      CMD_TICK: begin
        case (st.phase)
          PH_WARMUP: begin
            if (st.warmup_count != '0) begin
              st_next.warmup_count = st.warmup_count - 1'b1;
            end else begin
              st_next.phase = PH_READY;
            end
          end
          PH_READY: begin
            if (refresh_en) begin
              if (st.refresh_count != '0) begin
                st_next.refresh_count = st.refresh_count - 1'b1;
              end else begin
                st_next.pending = 1'b1;
              end
            end
            if (st_next.pending) begin
              start = 1'b1;
              if (item.update_done) begin
                // sleep keeps refresh count as stepped above
                st_next.pending = 1'b0;
                if (sleep_en) begin
                  st_next.phase       = PH_SLEEP;
                  st_next.sleep_count = load_count(cfg.sleep_period);
                end else begin
                  st_next.phase = PH_READY;
                  if (refresh_en) begin
                    st_next.refresh_count = load_count(cfg.refresh_period);
                  end
                end
              end else begin
                st_next.phase = PH_BUSY;
              end
            end
          end
          PH_BUSY: begin
            if (st.pending) begin
              poll = 1'b1;
              if (item.data_ready) begin
                st_next = fin;
              end
            end
          end
          PH_SLEEP: begin
            if (st.sleep_count != '0) begin
              st_next.sleep_count = st.sleep_count - 1'b1;
            end else begin
              st_next.phase = PH_READY;
              if (refresh_en) begin
                st_next.refresh_count = load_count(cfg.refresh_period);
              end
            end
          end
          // timeout, error: recover through finish
          default: begin
            st_next = fin;
          end
        endcase
      end
      CMD_INIT: begin
        if (warmup_en) begin
          st_next.phase        = PH_WARMUP;
          st_next.warmup_count = load_count(cfg.warmup_period);
        end else begin
          st_next.phase = PH_READY;
        end
      end
      CMD_REQUEST: begin
        st_next.pending = 1'b1;
      end
      default: begin
        st_next.phase = item.fault_kind ? PH_ERROR : PH_TIMEOUT;
      end
    endcase
  end

  // result item
  always_comb begin
    res.phase          = st_next.phase;
    res.update_pending = st_next.pending;
    res.start_update   = start;
    res.poll_busy      = poll;
  end

endmodule

// ----- hdl/sensor_sampling_sequencer_top.sv -----
// sensor_sampling_sequencer_top: state, period registers and result register
// depends on sss_pkg and sss_step
// result: an accepted item's result appears in the output register in the next cycle
// throughput: one item per cycle while the output is not stalled; a single next-state
// pass sits between the state registers and the result register, which frees itself as it is taken
// reset: phase ready, request clear, all counters and periods zero, no result held
module sensor_sampling_sequencer_top
  import sss_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  cfg_idx_t  cfg_index,
  input  period_t   cfg_data
);

  cfg_t       cfg;
  seq_state_t st;
  seq_state_t st_next;
  out_item_t  res;
  logic       in_accept;
  logic       out_valid_next;

  // configuration writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WARMUP:  cfg.warmup_period  <= cfg_data;
        CFG_SLEEP:   cfg.sleep_period   <= cfg_data;
        CFG_REFRESH: cfg.refresh_period <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake: stall only while a held result is itself stalled
  assign in_stall       = out_valid && out_stall;
  assign in_accept      = in_valid && !in_stall;
  assign out_valid_next = in_accept || (out_valid && out_stall);

  sss_step u_step (
    .st      (st),
    .cfg     (cfg),
    .item    (in_data),
    .st_next (st_next),
    .res     (res)
  );

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase         <= PH_READY;
      st.pending       <= 1'b0;
      st.warmup_count  <= '0;
      st.sleep_count   <= '0;
      st.refresh_count <= '0;
    end else if (in_accept) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data <= res;
    end
  end

  // a launch and a poll never share one item
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.start_update && out_data.poll_busy))
    else $error("start and poll strobes both set");

  // entering busy on a launch leaves the request outstanding
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.start_update && out_data.phase == PH_BUSY)
      |-> out_data.update_pending)
    else $error("busy after launch without pending request");

  // a poll is only made with a request outstanding
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.poll_busy && out_data.phase == PH_BUSY)
      |-> out_data.update_pending)
    else $error("poll left busy without pending request");

  // the state moves only on an accepted item
  assert property (@(posedge clk) disable iff (rst)
    !$past(in_accept) && !$past(rst) |-> $stable(st))
    else $error("sequencer state changed without an item");

endmodule
